FILE: hw/rtl/fifo_lock_with_wait_queue_top_defines.svh
// Assertion macros for the FIFO lock block.
// Used by the port checker; no other dependencies.
`ifndef FIFO_LOCK_WITH_WAIT_QUEUE_TOP_DEFINES_SVH
`define FIFO_LOCK_WITH_WAIT_QUEUE_TOP_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define FLQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// A signal keeps its value while a transfer is offered and not taken.
`define FLQ_ASSERT_STABLE(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy |=> $stable(sig))) \
    else $error("signal changed under stall");
`endif

FILE: hw/rtl/flq_pkg.sv
// Package for the FIFO lock block: command, event and status codes.
// No dependencies.
package flq_pkg;
  localparam int unsigned WaitersDefault = 16;
  localparam int unsigned IdW = 4;

  typedef enum logic [2:0] {
    CmdAcquire = 3'd0, CmdClaim = 3'd1, CmdCancel = 3'd2, CmdRelease = 3'd3, CmdClose = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    EvAcquired = 3'd0, EvQueued = 3'd1, EvRejected = 3'd2, EvCanceled = 3'd3,
    EvWake = 3'd4, EvError = 3'd5
  } ev_e;

  typedef enum logic [2:0] {
    StIdle = 3'd0, StQueued = 3'd1, StGranted = 3'd2, StRejected = 3'd3, StCanceled = 3'd4
  } st_e;

  typedef struct packed {
    logic [2:0]     cmd;
    logic [IdW-1:0] id;
  } req_t;

  typedef struct packed {
    logic [2:0]     ev;
    logic [IdW-1:0] id;
    logic           last;
  } res_t;
endpackage

FILE: hw/rtl/flq_front.sv
// Front part: a two-entry request queue.
// Depends on flq_pkg.
module flq_front import flq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic req_valid_o,
  input  logic req_ready_i,
  output req_t req_o
);
  req_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = req_valid_o && req_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end
endmodule

FILE: hw/rtl/flq_back.sv
// Back part: lock state, wait queue memory and the result sequencer.
// Depends on flq_pkg.
module flq_back import flq_pkg::*; #(
  parameter int unsigned Waiters = WaitersDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);
  localparam int unsigned QW = $clog2(Waiters);
  localparam int unsigned CW = $clog2(Waiters + 1);

  typedef enum logic [2:0] {
    SIdle, SRead, SFind, SShift, SClose, SGrant, SFinish
  } state_e;

  state_e state_q;
  logic held_q, shut_q, pgv_q, out_v_q;
  logic [IdW-1:0] pgid_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] idx_q;
  logic [2:0] stat_q [Waiters];
  logic [IdW-1:0] queue_q [Waiters];
  req_t cur_q;
  res_t out_q;
  logic [QW-1:0] cur_idx;
  logic [2:0] cur_st;

  assign cur_idx = QW'(cur_q.id);
  assign cur_st = stat_q[cur_idx];
  assign req_ready_o = state_q == SIdle && !out_v_q;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      held_q <= 1'b0;
      shut_q <= 1'b0;
      pgv_q <= 1'b0;
      pgid_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < Waiters; i++) stat_q[i] <= StIdle;
    end else begin
      if (out_v_q && res_ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (req_valid_i && req_ready_o) begin
            cur_q <= req_i;
            state_q <= SRead;
          end
        end
        SRead: begin
          state_q <= SIdle;
          out_v_q <= 1'b1;
          out_q <= '{EvError, cur_q.id, 1'b1};
          if (cur_q.cmd <= CmdCancel && 32'(cur_q.id) >= Waiters) begin
          end else if (cur_q.cmd == CmdAcquire) begin
            if (cur_st != StIdle) begin
            end else if (shut_q) out_q.ev <= EvRejected;
            else if (!held_q) begin
              held_q <= 1'b1;
              out_q.ev <= EvAcquired;
            end else if (32'(cnt_q) < Waiters) begin
              queue_q[cnt_q[QW-1:0]] <= cur_q.id;
              cnt_q <= cnt_q + 1'b1;
              stat_q[cur_idx] <= StQueued;
              out_q.ev <= EvQueued;
            end
          end else if (cur_q.cmd == CmdClaim) begin
            stat_q[cur_idx] <= StIdle;
            if (cur_st == StGranted) begin
              if (pgv_q && pgid_q == cur_q.id) pgv_q <= 1'b0;
              out_q.ev <= EvAcquired;
            end else if (cur_st == StRejected) out_q.ev <= EvRejected;
            else if (cur_st == StCanceled) out_q.ev <= EvCanceled;
            else if (cur_st == StQueued) begin
              out_v_q <= 1'b0;
              out_q.ev <= EvCanceled;
              idx_q <= '0;
              state_q <= SFind;
            end
          end else if (cur_q.cmd == CmdCancel) begin
            if (cur_st == StQueued) begin
              stat_q[cur_idx] <= StCanceled;
              out_v_q <= 1'b0;
              out_q.ev <= EvWake;
              idx_q <= '0;
              state_q <= SFind;
            end else if (cur_st == StGranted) begin
              stat_q[cur_idx] <= StCanceled;
              if (pgv_q && pgid_q == cur_q.id) pgv_q <= 1'b0;
              if (shut_q || cnt_q == '0) begin
                held_q <= 1'b0;
                out_q <= '{EvWake, cur_q.id, 1'b1};
              end else begin
                out_q <= '{EvWake, cur_q.id, 1'b0};
                state_q <= SGrant;
              end
            end else if (cur_st != StIdle) out_q.ev <= EvWake;
          end else if (cur_q.cmd == CmdRelease) begin
            out_v_q <= 1'b0;
            state_q <= SGrant;
          end else if (cur_q.cmd == CmdClose) begin
            out_v_q <= 1'b0;
            if (!shut_q) begin
              shut_q <= 1'b1;
              idx_q <= '0;
              state_q <= SClose;
            end
          end
        end
        SFind: begin
          if (queue_q[idx_q] == cur_q.id) state_q <= SShift;
          else idx_q <= idx_q + 1'b1;
        end
        SShift: begin
          if (32'(idx_q) + 1 < 32'(cnt_q)) begin
            queue_q[idx_q] <= queue_q[idx_q + 1'b1];
            idx_q <= idx_q + 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
            out_v_q <= 1'b1;
            out_q.last <= 1'b1;
            state_q <= SIdle;
          end
        end
        SClose: begin
          if (!out_v_q || res_ready_i) begin
            if (32'(idx_q) < 32'(cnt_q)) begin
              if (stat_q[QW'(queue_q[idx_q])] == StQueued)
                stat_q[QW'(queue_q[idx_q])] <= StRejected;
              out_v_q <= 1'b1;
              out_q <= '{EvWake, queue_q[idx_q],
                         !pgv_q && 32'(idx_q) + 1 == 32'(cnt_q)};
              if (32'(idx_q) + 1 == 32'(cnt_q)) begin
                cnt_q <= '0;
                if (!pgv_q) state_q <= SIdle;
                else state_q <= SFinish;
              end else idx_q <= idx_q + 1'b1;
            end else begin
              cnt_q <= '0;
              state_q <= pgv_q ? SFinish : SIdle;
            end
          end
        end
        SFinish: begin
          if (!out_v_q || res_ready_i) begin
            if (stat_q[QW'(pgid_q)] == StGranted) begin
              stat_q[QW'(pgid_q)] <= StRejected;
              held_q <= 1'b0;
            end
            out_v_q <= 1'b1;
            out_q <= '{EvWake, pgid_q, 1'b1};
            pgv_q <= 1'b0;
            state_q <= SIdle;
          end
        end
        SGrant: begin
          if (!out_v_q || res_ready_i) begin
            if (shut_q || cnt_q == '0) begin
              held_q <= 1'b0;
              state_q <= SIdle;
            end else begin
              state_q <= SShift;
              idx_q <= '0;
              stat_q[QW'(queue_q[0])] <= StGranted;
              pgid_q <= queue_q[0];
              pgv_q <= 1'b1;
              cur_q.id <= queue_q[0];
              out_v_q <= 1'b0;
              out_q <= '{EvWake, queue_q[0], 1'b1};
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

FILE: hw/rtl/fifo_lock_with_wait_queue_top.sv
// Channel | dir | tdata fields (low bit up)        | tuser
// s_axis  | in  | command[2:0], waiter_id[6:3]     | -
// m_axis  | out | event_res[2:0], target_id[6:3]   | -    tlast = last
// A close sends its wake results one after another, each when the output is free.
// Removing or granting a queued waiter walks the queue memory, one entry per
// cycle.
// Reset is asynchronous and clears the lock state; results hold under stall.
module fifo_lock_with_wait_queue_top import flq_pkg::*; #(
  parameter int unsigned Waiters = WaitersDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // command, waiter_id
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // event_res, target_id
  output logic       m_axis_tlast
);
  req_t in_req, req;
  res_t res;
  logic rv, rr;
  assign in_req = '{s_axis_tdata[2:0], s_axis_tdata[6:3]};

  flq_front u_front (.clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .req_valid_o(rv), .req_ready_i(rr), .req_o(req));
  flq_back #(.Waiters(Waiters)) u_back (.clk_i, .rst_ni, .req_valid_i(rv), .req_ready_o(rr),
    .req_i(req), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res));

  assign m_axis_tdata = {1'b0, res.id, res.ev};
  assign m_axis_tlast = res.last;
endmodule

FILE: hw/rtl/flq_checker.sv
// Port checker for the FIFO lock block, bound to the top level.
// Depends on flq_pkg and fifo_lock_with_wait_queue_top_defines.svh.
`include "fifo_lock_with_wait_queue_top_defines.svh"
module flq_checker import flq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic m_axis_tlast
);
  `FLQ_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `FLQ_ASSERT(a_ev, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[2:0] <= EvError)
  `FLQ_ASSERT(a_pad, clk_i, rst_ni, m_axis_tvalid |-> !m_axis_tdata[7])
  `FLQ_ASSERT_STABLE(a_data, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `FLQ_ASSERT_STABLE(a_last, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tlast)
endmodule

bind fifo_lock_with_wait_queue_top flq_checker u_chk (.clk_i, .rst_ni, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast);

FILE: verif/testbench.sv
// Self-checking testbench for the FIFO lock with wait queue.
// Drives request transfers, predicts wake/grant events and compares each result.
// Depends on flq_pkg and fifo_lock_with_wait_queue_top.
module testbench;
  import flq_pkg::*;

  localparam logic [2:0] CmdBadLo = 3'd5;
  localparam logic [2:0] CmdBadHi = 3'd7;

  typedef struct packed {
    logic [2:0] ev;
    logic [3:0] id;
    logic       last;
  } event_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  fifo_lock_with_wait_queue_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // Predictor state.
  logic       lk_held, lk_shut, grant_valid;
  logic [3:0] grant_id;
  logic [3:0] wait_q[$];
  st_e        wstat[16];

  event_t     expected_events[$];
  logic [7:0] pending_reqs[$];
  int         errors, results_seen, reqs_sent;
  int         send_idle_pct, recv_idle_pct, hold_left;
  bit         send_pause, hold_go, hold_seen;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  task automatic push_event(input ev_e ev, input logic [3:0] id);
    event_t e;
    e.ev = ev;
    e.id = id;
    e.last = 1'b0;
    expected_events = {expected_events, e};
  endtask

  task automatic drop_waiter(input logic [3:0] id);
    foreach (wait_q[i]) begin
      if (wait_q[i] == id) begin
        wait_q.delete(i);
        return;
      end
    end
  endtask

  task automatic grant_next();
    logic [3:0] id;
    if (lk_shut || wait_q.size() == 0) begin
      lk_held = 1'b0;
    end else begin
      id = wait_q[0];
      wait_q.delete(0);
      wstat[id] = StGranted;
      grant_id = id;
      grant_valid = 1'b1;
      push_event(EvWake, id);
    end
  endtask

  task automatic predict_request(input logic [2:0] cmd, input logic [3:0] id);
    int   n0;
    st_e  st;
    event_t e;
    n0 = expected_events.size();
    st = wstat[id];
    case (cmd)
      CmdAcquire: begin
        if (st != StIdle) push_event(EvError, id);
        else if (lk_shut) push_event(EvRejected, id);
        else if (!lk_held) begin
          lk_held = 1'b1;
          push_event(EvAcquired, id);
        end else if (wait_q.size() < 16) begin
          wait_q = {wait_q, id};
          wstat[id] = StQueued;
          push_event(EvQueued, id);
        end else push_event(EvError, id);
      end
      CmdClaim: begin
        if (st == StGranted) begin
          if (grant_valid && grant_id == id) grant_valid = 1'b0;
          push_event(EvAcquired, id);
        end else if (st == StRejected) push_event(EvRejected, id);
        else if (st == StCanceled) push_event(EvCanceled, id);
        else if (st == StQueued) begin
          drop_waiter(id);
          push_event(EvCanceled, id);
        end else push_event(EvError, id);
        wstat[id] = StIdle;
      end
      CmdCancel: begin
        if (st == StQueued) begin
          wstat[id] = StCanceled;
          drop_waiter(id);
          push_event(EvWake, id);
        end else if (st == StGranted) begin
          wstat[id] = StCanceled;
          if (grant_valid && grant_id == id) grant_valid = 1'b0;
          push_event(EvWake, id);
          grant_next();
        end else if (st == StIdle) push_event(EvError, id);
        else push_event(EvWake, id);
      end
      CmdRelease: grant_next();
      CmdClose: begin
        if (!lk_shut) begin
          lk_shut = 1'b1;
          foreach (wait_q[i]) begin
            if (wstat[wait_q[i]] == StQueued) wstat[wait_q[i]] = StRejected;
            push_event(EvWake, wait_q[i]);
          end
          wait_q.delete();
          if (grant_valid) begin
            if (wstat[grant_id] == StGranted) begin
              wstat[grant_id] = StRejected;
              lk_held = 1'b0;
            end
            push_event(EvWake, grant_id);
            grant_valid = 1'b0;
          end
        end
      end
      default: push_event(EvError, id);
    endcase
    if (expected_events.size() > n0) begin
      e = expected_events[expected_events.size() - 1];
      e.last = 1'b1;
      expected_events[expected_events.size() - 1] = e;
    end
  endtask

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      lk_held = 1'b0;
      lk_shut = 1'b0;
      grant_valid = 1'b0;
      grant_id = '0;
      wait_q.delete();
      foreach (wstat[i]) wstat[i] = StIdle;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(s_axis_tdata[2:0], s_axis_tdata[6:3]);
        reqs_sent++;
      end
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_reqs.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_reqs[0];
          pending_reqs.delete(0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result ev=%0d id=%0d last=%0b", $time,
                   m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tlast);
          errors++;
        end else begin
          event_t e;
          e = expected_events[0];
          expected_events.delete(0);
          if (e.ev != m_axis_tdata[2:0] || e.id != m_axis_tdata[6:3] ||
              e.last != m_axis_tlast) begin
            $display("%0t: mismatch expected ev=%0d id=%0d last=%0b actual ev=%0d id=%0d last=%0b",
                     $time, e.ev, e.id, e.last, m_axis_tdata[2:0], m_axis_tdata[6:3],
                     m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] pack_req(input logic [2:0] cmd, input logic [3:0] id);
    return {1'b0, id, cmd};
  endfunction

  task automatic add_req(input logic [2:0] cmd, input logic [3:0] id);
    pending_reqs = {pending_reqs, pack_req(cmd, id)};
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_reqs.size() > 0 || s_axis_tvalid || expected_events.size() > 0)
           && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  // Mostly well-formed lock traffic with random waiters.
  task automatic add_random(input int count);
    int k;
    logic [2:0] cmd;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: cmd = CmdAcquire;
        7, 8, 9: cmd = CmdClaim;
        10, 11: cmd = CmdCancel;
        12, 13, 14, 15, 16: cmd = CmdRelease;
        17: cmd = ($urandom_range(3) == 0) ? CmdClose : CmdRelease;
        default: cmd = 3'($urandom_range(7));
      endcase
      add_req(cmd, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    int k;
    send_pause = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: acquire, queue fifteen waiters, grants, cancels, claims.
    add_req(CmdClaim, 4'd0);
    add_req(CmdCancel, 4'd15);
    add_req(CmdRelease, 4'd0);
    for (k = 0; k < 16; k++) add_req(CmdAcquire, 4'(k));
    add_req(CmdAcquire, 4'd15);
    add_req(CmdCancel, 4'd7);
    add_req(CmdClaim, 4'd9);
    add_req(CmdRelease, 4'd0);
    add_req(CmdCancel, 4'd1);
    add_req(CmdBadHi, 4'd15);
    add_req(CmdBadLo, 4'd0);
    drain();

    // Long receiver hold-off while requests keep coming.
    hold_go = ~hold_go;
    add_random(20);
    drain();

    // Sender pauses until every expected result has come.
    add_random(30);
    repeat (60) @(posedge clk_i);
    send_pause = 1'b1;
    while (expected_events.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    send_pause = 1'b0;
    drain();

    send_idle_pct = 68;
    recv_idle_pct = 19;
    add_req(CmdClose, 4'd0);
    add_req(CmdAcquire, 4'd3);
    add_req(CmdClose, 4'd0);
    add_req(CmdRelease, 4'd0);
    for (k = 0; k < 16; k++) add_req(CmdClaim, 4'(k));
    add_random(20);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(15);
    drain();

    $display("Covered %0d request transfers and %0d result transfers,", reqs_sent,
             results_seen);
    $display("including a full queue, grant hand-offs, cancels, close and long stalls.");
    if (errors == 0 && expected_events.size() == 0 && pending_reqs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
